// ===== rtl/dmcw_pkg.sv =====
// Package for the chunked mailbox writer.
// Holds the request and result types, the command and status codes and the window map.
// No dependencies.
package dmcw_pkg;

    localparam int CHUNK_WORDS  = 32;
    localparam int WINDOW_COUNT = 5;
    localparam int MAX_RESULTS  = 3;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [17:0] WINDOW_BASE0 = 18'h3F000;
    localparam logic [17:0] CTRL0_OFFSET = 18'h00080;
    localparam logic [17:0] CTRL1_OFFSET = 18'h00084;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  win_num;
        logic [15:0] target_code;
        logic [31:0] start_destination;
        logic [15:0] total_words;
        logic [31:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [17:0] bus_address;
        logic [31:0] bus_data;
        logic        wait_busy_clear;
        logic        status;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]            count;
        out_item_t [MAX_RESULTS-1:0] item;
    } step_res_t;

endpackage

// ===== rtl/dsp_mailbox_chunked_writer_core.sv =====
// Chunked mailbox writer for a DSP register window, top level.
// Request channel: in_valid/in_stall/in_data. Result channel: out_valid/out_stall/out_data.
// Request and result structs come from dmcw_pkg; transfer state lives in dmcw_engine.
//
// A start request (cmd 0) opens a transfer on one window; each data request
// (cmd 1) then produces one bus write into the window data area. At the end
// of each chunk of up to 32 words, or at the last word, two control writes
// follow the data write. A start with an invalid window gives one result
// with status set.
//
// Results are registered into the result queue; out_valid comes from its
// level. Throughput: one request per cycle while each request gives at most
// one result and out_stall is low; a chunk end gives three results, which
// leave through the four-entry result queue one per cycle while out_stall
// is low. in_stall is high while the queue cannot absorb three more results,
// so a stalled receiver backs up into the request side.
// Reset clears the transfer state and empties the queue.
module dsp_mailbox_chunked_writer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dmcw_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output dmcw_pkg::out_item_t out_data
);
    import dmcw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    out_item_t          queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic      accept;
    logic      pop;
    step_res_t res;

    assign in_stall  = count_reg > CNT_W'(QUEUE_DEPTH - MAX_RESULTS);
    assign accept    = in_valid && !in_stall;
    assign out_valid = count_reg != '0;
    assign pop       = out_valid && !out_stall;
    assign out_data  = queue_mem[head_reg];

    dmcw_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .res    (res)
    );

    always_comb
    begin
        head_next  = head_reg + PTR_W'(pop);
        tail_next  = tail_reg + PTR_W'(res.count);
        count_next = count_reg + CNT_W'(res.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (2'(i) < res.count)
            begin
                queue_mem[tail_reg + PTR_W'(i)] <= res.item[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_chunk_end_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (res.count == 2'd3) |=> out_valid)
        else $error("chunk end results not presented");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && res.count == 2'd0) |=> $stable(count_reg))
        else $error("queue level moved with no request or pop");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with mismatched pointers");

endmodule

// ===== rtl/dmcw_engine.sv =====
// Transfer state and per-request result generation for the mailbox writer.
// Turns one accepted request combinationally into zero to three results: bus writes, or one invalid-window status.
// Depends on dmcw_pkg.
module dmcw_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  dmcw_pkg::in_item_t  item,
    output dmcw_pkg::step_res_t res
);
    import dmcw_pkg::*;

    logic        open_reg,  open_next;
    logic [17:0] base_reg,  base_next;
    logic [15:0] sel_reg,   sel_next;
    logic [31:0] dest_reg,  dest_next;
    logic [15:0] words_reg, words_next;
    logic [5:0]  slot_reg,  slot_next;

    logic [15:0] words_dec;
    logic [5:0]  slot_inc;
    logic        chunk_end;

    assign words_dec = words_reg - 16'd1;
    assign slot_inc  = slot_reg + 6'd1;
    assign chunk_end = (slot_inc >= 6'(CHUNK_WORDS)) || (words_dec == 16'd0);

    always_comb
    begin
        open_next  = open_reg;
        base_next  = base_reg;
        sel_next   = sel_reg;
        dest_next  = dest_reg;
        words_next = words_reg;
        slot_next  = slot_reg;
        res        = '0;
        if (accept)
        begin
            if (item.cmd == CMD_START)
            begin
                open_next  = 1'b0;
                slot_next  = '0;
                words_next = '0;
                if ({1'b0, item.win_num} >= 4'(WINDOW_COUNT))
                begin
                    res.count          = 2'd1;
                    res.item[0].status = STATUS_INVALID;
                    res.item[0].last   = 1'b1;
                end
                else
                begin
                    base_next = WINDOW_BASE0 + {7'd0, item.win_num, 8'd0};
                    sel_next  = item.target_code;
                    dest_next = item.start_destination;
                    if (item.total_words != 16'd0)
                    begin
                        words_next = item.total_words;
                        open_next  = 1'b1;
                    end
                end
            end
            else if (open_reg)
            begin
                words_next                  = words_dec;
                slot_next                   = slot_inc;
                res.count                   = 2'd1;
                res.item[0].bus_address     = base_reg + {10'd0, slot_reg, 2'b00};
                res.item[0].bus_data        = item.data_word;
                res.item[0].wait_busy_clear = (slot_reg == 6'd0);
                res.item[0].status          = STATUS_OK;
                res.item[0].last            = !chunk_end;
                if (chunk_end)
                begin
                    res.count               = 2'd3;
                    res.item[1].bus_address = base_reg + CTRL0_OFFSET;
                    res.item[1].bus_data    = {10'd0, slot_inc, dest_reg[31:16]};
                    res.item[1].status      = STATUS_OK;
                    res.item[2].bus_address = base_reg + CTRL1_OFFSET;
                    res.item[2].bus_data    = {dest_reg[15:0], sel_reg};
                    res.item[2].status      = STATUS_OK;
                    res.item[2].last        = 1'b1;
                    dest_next               = dest_reg + {26'd0, slot_inc};
                    slot_next               = '0;
                    if (words_dec == 16'd0)
                    begin
                        open_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            base_reg  <= '0;
            sel_reg   <= '0;
            dest_reg  <= '0;
            words_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            open_reg  <= open_next;
            base_reg  <= base_next;
            sel_reg   <= sel_next;
            dest_reg  <= dest_next;
            words_reg <= words_next;
            slot_reg  <= slot_next;
        end
    end

    // an open transfer always has words pending
    a_open_has_words: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> words_reg != 16'd0)
        else $error("open transfer with no words left");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (words_reg == 16'd0 && slot_reg == 6'd0))
        else $error("closed transfer left residual state");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < 6'(CHUNK_WORDS))
        else $error("chunk slot out of range");

endmodule
